>>> design/tsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsa_pkg
// shared types and constants of the triangle strip assembler
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam int SLOT_W   = 16;
	localparam int FLAGS_W  = 16;
	localparam int VNUM_W   = 14;
	localparam int BASE_W   = 32;
	localparam int VCOUNT_W = 16;
	localparam int AREA_W   = 19;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [SLOT_W-1:0]  SEPARATOR_CODE = 16'hFFFF;
	localparam logic [SLOT_W-1:0]  SLOT_OFFSET    = 16'd2;
	// floor(x / 6) == (x * RECIP6) >> RECIP6_SHIFT for every 16-bit x
	localparam logic [15:0]        RECIP6         = 16'd43691;
	localparam int                 RECIP6_SHIFT   = 18;
	// (6v + 5) * 4 + 12 == 4 * (6v) + 32
	localparam logic [19:0]        NORMAL_END_OFS = 20'd32;
	localparam int                 REVERSE_BIT    = 15;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_AREA  = 8'd1;

	localparam logic [1:0] WINDOW_FULL = 2'd2;

	typedef struct packed {
		logic              ok;
		logic [VNUM_W-1:0] vnum;
	} slot_chk_t;

endpackage
`default_nettype wire

>>> design/tsa_slot_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsa_slot_check
// classifies one strip record and yields its vertex number
// ----------------------------------------------------------------------------
module tsa_slot_check import tsa_pkg::*; (
	input  wire logic [SLOT_W-1:0]   vertex_slot,
	input  wire logic [FLAGS_W-1:0]  flag_word,
	input  wire logic [VCOUNT_W-1:0] vertex_count,
	input  wire logic [AREA_W-1:0]   vertex_area_bytes,
	output slot_chk_t                chk
);

	logic [SLOT_W-1:0] rel;
	logic [31:0]       prod;
	logic [VNUM_W-1:0] quot;
	logic [SLOT_W-1:0] quot_ext;
	logic [SLOT_W-1:0] six_quot;
	logic [19:0]       normal_end;

	assign rel        = vertex_slot - SLOT_OFFSET;
	assign prod       = 32'(rel) * 32'(RECIP6);
	assign quot       = prod[RECIP6_SHIFT+VNUM_W-1:RECIP6_SHIFT];
	assign quot_ext   = {2'b00, quot};
	assign six_quot   = (quot_ext << 2) + (quot_ext << 1);
	assign normal_end = {2'b00, rel, 2'b00} + NORMAL_END_OFS;

	always_comb begin
		chk.vnum = quot;
		chk.ok   = (vertex_slot != SEPARATOR_CODE)
			&& (flag_word != SEPARATOR_CODE)
			&& (vertex_slot >= SLOT_OFFSET)
			&& (six_quot == rel)
			&& (quot_ext < vertex_count)
			&& (normal_end <= {1'b0, vertex_area_bytes});
	end

endmodule
`default_nettype wire

>>> design/triangle_strip_assembler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_strip_assembler_top
// turns a stream of strip records into a list of triangles
// ----------------------------------------------------------------------------
// path: input register, then result register, which drives the triangle on m_axis
// throughput: one record per cycle unless m_axis stalls; single input and output register
// reset: arst_n clears the window, the base count, both registers and the
// valid flags; no clearing pass, the block is ready right after reset
// ----------------------------------------------------------------------------
module triangle_strip_assembler_top import tsa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [31:0]           s_axis_tdata,  // vertex_slot, flag_word
	input  wire logic                  s_axis_tlast,  // stream_end
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [79:0]                m_axis_tdata,  // corner_a, corner_b, corner_c, base_index
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [VCOUNT_W-1:0] vertex_count_q;
	logic [AREA_W-1:0]   vertex_area_q;

	logic                s1_valid;
	logic [SLOT_W-1:0]   slot_s1;
	logic [FLAGS_W-1:0]  flags_s1;
	logic                last_s1;

	logic [VNUM_W-1:0]   older_q;
	logic [VNUM_W-1:0]   newer_q;
	logic [1:0]          fill_q;
	logic [BASE_W-1:0]   emitted_q;

	logic                out_valid_s2;
	logic [VNUM_W-1:0]   corner_a_s2;
	logic [VNUM_W-1:0]   corner_b_s2;
	logic [VNUM_W-1:0]   corner_c_s2;
	logic [BASE_W-1:0]   base_s2;

	slot_chk_t           chk;
	logic                advance;
	logic                fire;
	logic                emit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			vertex_area_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERTEX_COUNT: vertex_count_q <= cfg_data[VCOUNT_W-1:0];
				REG_VERTEX_AREA:  vertex_area_q  <= cfg_data[AREA_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance       = !out_valid_s2 || m_axis_tready;
	assign s_axis_tready = !s1_valid || advance;
	assign fire          = s1_valid && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			slot_s1  <= s_axis_tdata[15:0];
			flags_s1 <= s_axis_tdata[31:16];
			last_s1  <= s_axis_tlast;
		end
	end

	tsa_slot_check u_slot_check (
		.vertex_slot       (slot_s1),
		.flag_word         (flags_s1),
		.vertex_count      (vertex_count_q),
		.vertex_area_bytes (vertex_area_q),
		.chk               (chk)
	);

	assign emit = chk.ok && (fill_q == WINDOW_FULL);

	// strip window and running base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q   <= '0;
			newer_q   <= '0;
			fill_q    <= '0;
			emitted_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				older_q   <= '0;
				newer_q   <= '0;
				fill_q    <= '0;
				emitted_q <= '0;
			end else if (!chk.ok) begin
				fill_q <= '0;
			end else begin
				older_q <= newer_q;
				newer_q <= chk.vnum;
				if (emit) begin
					emitted_q <= emitted_q + BASE_W'(3);
				end else begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			if (flags_s1[REVERSE_BIT]) begin
				corner_a_s2 <= chk.vnum;
				corner_c_s2 <= older_q;
			end else begin
				corner_a_s2 <= older_q;
				corner_c_s2 <= chk.vnum;
			end
			corner_b_s2 <= newer_q;
			base_s2     <= emitted_q;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {6'b000000, base_s2, corner_c_s2, corner_b_s2, corner_a_s2};

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (emitted_q == '0 && fill_q == '0))
		else $error("window or base not cleared after stream end");

	a_base_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit && !last_s1) |=> (emitted_q == $past(emitted_q) + BASE_W'(3)))
		else $error("base index did not advance by one triangle");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("window fill overflow");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s1_valid))
		else $error("result shown without a record in the input register");
`endif

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the triangle strip assembler. Strip records go in on s_axis
// and a scoreboard class predicts the triangles from its own copy of the
// window, the base count and both registers. Each triangle on m_axis is
// compared field by field with the oldest prediction. A directed part covers
// the edge cases, then random phases run under several register settings
// with sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import tsa_pkg::*;

	localparam int STRIDE       = 6;
	localparam int NORMAL_OFS   = 5;
	localparam int VEC_BYTES    = 12;
	localparam int AREA_BASE    = NORMAL_OFS * 4 + VEC_BYTES;
	localparam int AREA_STEP    = STRIDE * 4;
	localparam int MAX_VNUM     = (32'hFFFE - 2) / STRIDE;
	localparam int DRAIN_GAP    = 6;
	localparam int LONG_HOLD    = 400;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 180;
	localparam int TIMEOUT_NS   = 3_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

	typedef struct packed {
		logic [VNUM_W-1:0] corner_a;
		logic [VNUM_W-1:0] corner_b;
		logic [VNUM_W-1:0] corner_c;
		logic [BASE_W-1:0] base_index;
	} triangle_t;

	class triangle_scoreboard;
		logic [VCOUNT_W-1:0] vertex_count = '0;
		logic [AREA_W-1:0]   vertex_area = '0;
		logic [VNUM_W-1:0]   older_vtx = '0;
		logic [VNUM_W-1:0]   newer_vtx = '0;
		logic [1:0]          fill = '0;
		logic [BASE_W-1:0]   base_count = '0;
		triangle_t           expected_tris[$];
		int                  errors = 0;
		int                  n_records = 0;
		int                  n_checked = 0;

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
			if (idx == REG_VERTEX_COUNT)
				vertex_count = data[VCOUNT_W-1:0];
			else if (idx == REG_VERTEX_AREA)
				vertex_area = data[AREA_W-1:0];
		endfunction

		// highest vertex number that passes both limits, -1 if none
		function int top_vertex();
			int va;
			int m;
			if (vertex_count == 0 || vertex_area < AREA_BASE)
				return -1;
			va = (int'(vertex_area) - AREA_BASE) / AREA_STEP;
			m = int'(vertex_count) - 1;
			if (va < m)
				m = va;
			if (m > MAX_VNUM)
				m = MAX_VNUM;
			return m;
		endfunction

		function bit slot_ok(input logic [SLOT_W-1:0] slot, output logic [VNUM_W-1:0] vnum);
			int unsigned rel;
			int unsigned v;
			int unsigned nend;
			vnum = '0;
			if (slot < SLOT_OFFSET)
				return 1'b0;
			rel = slot - SLOT_OFFSET;
			if ((rel % STRIDE) != 0)
				return 1'b0;
			v = rel / STRIDE;
			if (v >= vertex_count)
				return 1'b0;
			nend = (v * STRIDE + NORMAL_OFS) * 4 + VEC_BYTES;
			if (nend > vertex_area)
				return 1'b0;
			vnum = v[VNUM_W-1:0];
			return 1'b1;
		endfunction

		function void note_record(input logic [SLOT_W-1:0] slot, input logic [FLAGS_W-1:0] flags,
				input logic last);
			logic [VNUM_W-1:0] v;
			triangle_t t;
			n_records++;
			if (slot == SEPARATOR_CODE || flags == SEPARATOR_CODE || !slot_ok(slot, v)) begin
				fill = '0;
			end else if (fill >= WINDOW_FULL) begin
				if (flags[REVERSE_BIT]) begin
					t.corner_a = v;
					t.corner_b = newer_vtx;
					t.corner_c = older_vtx;
				end else begin
					t.corner_a = older_vtx;
					t.corner_b = newer_vtx;
					t.corner_c = v;
				end
				t.base_index = base_count;
				expected_tris = {expected_tris, t};
				base_count = base_count + BASE_W'(3);
				older_vtx = newer_vtx;
				newer_vtx = v;
			end else begin
				older_vtx = newer_vtx;
				newer_vtx = v;
				fill = fill + 2'd1;
			end
			if (last) begin
				fill = '0;
				older_vtx = '0;
				newer_vtx = '0;
				base_count = '0;
			end
		endfunction

		function int pending();
			return expected_tris.size();
		endfunction

		function void check_triangle(input logic [79:0] d);
			triangle_t e;
			triangle_t a;
			if (expected_tris.size() == 0) begin
				$error("unexpected triangle: tdata %h", d);
				errors++;
				return;
			end
			e = expected_tris.pop_front();
			a.corner_a = d[13:0];
			a.corner_b = d[27:14];
			a.corner_c = d[41:28];
			a.base_index = d[73:42];
			n_checked++;
			if (a.corner_a !== e.corner_a) begin
				$error("corner_a mismatch: expected %0d, actual %0d", e.corner_a, a.corner_a);
				errors++;
			end
			if (a.corner_b !== e.corner_b) begin
				$error("corner_b mismatch: expected %0d, actual %0d", e.corner_b, a.corner_b);
				errors++;
			end
			if (a.corner_c !== e.corner_c) begin
				$error("corner_c mismatch: expected %0d, actual %0d", e.corner_c, a.corner_c);
				errors++;
			end
			if (a.base_index !== e.base_index) begin
				$error("base_index mismatch: expected %0d, actual %0d", e.base_index, a.base_index);
				errors++;
			end
			if (d[79:74] !== 6'd0) begin
				$error("tdata pad mismatch: expected %0d, actual %0d", 6'd0, d[79:74]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [79:0]           m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	triangle_scoreboard sb = new();
	int send_pct = 0;
	int recv_pct = 0;
	int hold_left = 0;
	int n_settings = 0;

	triangle_strip_assembler_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// receiver: random stalls plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else begin
			m_axis_tready = ($urandom_range(99) >= recv_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_triangle(m_axis_tdata);
	end

	task automatic send_record(input logic [SLOT_W-1:0] slot, input logic [FLAGS_W-1:0] flags,
			input logic last);
		while ($urandom_range(99) < send_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {flags, slot};
		s_axis_tlast = last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_record(slot, flags, last);
		@(negedge clk);
	endtask

	task automatic drain_block();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] count, input logic [CFG_DATA_W-1:0] area);
		drain_block();
		write_reg(REG_VERTEX_COUNT, count);
		write_reg(REG_VERTEX_AREA, area);
		n_settings++;
	endtask

	function automatic logic [SLOT_W-1:0] pick_slot();
		int vmax;
		int r;
		int v;
		vmax = sb.top_vertex();
		r = $urandom_range(99);
		if (vmax >= 0 && r < 78) begin
			case ($urandom_range(3))
				0: v = vmax;
				1: v = 0;
				default: v = $urandom_range(vmax, 0);
			endcase
			return SLOT_W'(v * STRIDE + 2);
		end else if (r < 86) begin
			if ($urandom_range(1) == 1 && vmax < MAX_VNUM)
				return SLOT_W'((vmax + 1) * STRIDE + 2);
			return SLOT_W'($urandom_range(MAX_VNUM - 1, 0) * STRIDE + 2 + $urandom_range(5, 1));
		end else if (r < 91) begin
			return SEPARATOR_CODE;
		end
		return SLOT_W'($urandom_range(16'hFFFF, 0));
	endfunction

	function automatic logic [FLAGS_W-1:0] pick_flags();
		logic [FLAGS_W-1:0] f;
		if ($urandom_range(99) < 4)
			return SEPARATOR_CODE;
		f = FLAGS_W'($urandom_range(16'hFFFF, 0));
		if (f == SEPARATOR_CODE)
			f[0] = 1'b0;
		return f;
	endfunction

	initial begin
		#(TIMEOUT_NS);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [CFG_DATA_W-1:0] counts[PHASES];
		logic [CFG_DATA_W-1:0] areas[PHASES];
		int send_modes[PHASES];
		int recv_modes[PHASES];

		counts = '{32'hFFFF_FFFF, 200, 120, 1, 0, 65535, 0, 65535};
		areas  = '{32'hFFFF_FFFF, 24 * 120 + 32, 524287, 32, 0, 524287, 0, 31};
		send_modes = '{0, 60, 0, 16, 0, 0, 60, 16};
		recv_modes = '{0, 0, 60, 16, 60, 0, 0, 16};
		counts[6] = $urandom;
		areas[6] = $urandom;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: area limit is the tighter one here
		apply_setting(16, 24 * 10 + 32);
		send_record(16'd0, 16'h0000, 1'b0);
		send_record(16'd1, 16'h0000, 1'b0);
		send_record(16'd2, 16'h0000, 1'b0);
		send_record(16'd8, 16'h1234, 1'b0);
		send_record(16'd14, 16'h0001, 1'b0);
		send_record(16'd20, 16'h8000, 1'b0);
		send_record(16'd9, 16'h0000, 1'b0);
		send_record(16'd26, 16'h0000, 1'b0);
		send_record(SEPARATOR_CODE, 16'h0000, 1'b0);
		send_record(16'd38, 16'h0000, 1'b0);
		send_record(16'd44, 16'h0000, 1'b0);
		send_record(16'd50, SEPARATOR_CODE, 1'b0);
		send_record(16'd62, 16'h0000, 1'b0);
		send_record(16'd68, 16'h0000, 1'b0);
		send_record(16'd56, 16'h0000, 1'b0);
		send_record(16'd62, 16'h0000, 1'b0);
		send_record(16'd62, 16'h7FFF, 1'b1);
		send_record(16'd2, 16'h0000, 1'b0);
		send_record(16'd8, 16'h0000, 1'b0);
		send_record(16'd14, 16'h8000, 1'b0);
		// count limit is the tighter one
		apply_setting(3, 32'hFFFF_FFFF);
		send_record(16'd20, 16'h0000, 1'b0);
		send_record(16'd2, 16'h0000, 1'b0);
		send_record(16'd8, 16'h0000, 1'b0);
		send_record(16'd14, 16'hFFFE, 1'b0);
		send_record(SEPARATOR_CODE, SEPARATOR_CODE, 1'b1);
		// highest vertex number
		apply_setting(65535, 524287);
		send_record(16'hFFFE, 16'h0000, 1'b0);
		send_record(16'hFFFE, 16'h0000, 1'b0);
		send_record(16'hFFFE, 16'hFFFE, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			apply_setting(counts[p], areas[p]);
			if (p == 6) begin
				write_reg(REG_UNUSED, $urandom);
				write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
			end
			send_pct = send_modes[p];
			recv_pct = recv_modes[p];
			if (p == 5) begin
				@(posedge clk);
				hold_left = LONG_HOLD;
				@(negedge clk);
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_record(pick_slot(), pick_flags(), ($urandom_range(39) == 0));
		end

		drain_block();
		send_pct = 0;
		recv_pct = 0;
		repeat (DRAIN_GAP) @(negedge clk);

		$display("run covered %0d strip records under %0d register settings, %0d triangles compared",
			sb.n_records, n_settings, sb.n_checked);
		$display("with sender gaps, receiver stalls, a long output hold-off and both limit kinds");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
